/* rtl/icv_pkg.sv */
// Types, constants and helper functions shared by the checksum verifier modules.
package icv_pkg;

  // Check kinds as carried through the block; an unused opcode maps to IPV4_HDR.
  typedef enum logic [2:0] {
    KIND_IPV4_HDR = 3'd0,
    KIND_TCP4     = 3'd1,
    KIND_UDP4     = 3'd2,
    KIND_ICMP4    = 3'd3,
    KIND_TCP6     = 3'd4,
    KIND_UDP6     = 3'd5,
    KIND_ICMP6    = 3'd6
  } kind_e;

  // Verdict codes reported with each result.
  typedef enum logic [1:0] {
    STATUS_GOOD     = 2'd0,
    STATUS_BAD      = 2'd1,
    STATUS_LENGTH   = 2'd2,
    STATUS_UDP_ZERO = 2'd3
  } status_e;

  localparam logic [15:0] PROTO_TCP    = 16'd6;
  localparam logic [15:0] PROTO_UDP    = 16'd17;
  localparam logic [15:0] PROTO_ICMP6  = 16'd58;
  localparam logic [17:0] MIN_LEN_HDR  = 18'd20;
  localparam logic [17:0] MIN_LEN_UDP  = 18'd8;
  localparam logic [17:0] MIN_LEN_ICMP = 18'd4;
  localparam logic [16:0] UDP_FIELD_OFFSET = 17'd6;
  localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;
  localparam int unsigned QUEUE_DEPTH  = 4;

  // One classified word as it travels from the front part to the back part.
  typedef struct packed {
    logic        first;
    logic        last;
    logic        both;
    kind_e       kind;
    logic [15:0] word;     // data word, low byte masked for an odd tail
    logic [15:0] contrib;  // folded word plus pseudo-header seed on a first word
  } icv_item_t;

  // A segment that has ended and waits for its verdict.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] sum;
    logic [16:0] bytes;
    logic [15:0] udp;
  } icv_job_t;

  // Ones' complement add of two 16-bit values with end-around carry.
  function automatic logic [15:0] oc_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Plain sum of the four 16-bit words of a 64-bit value.
  function automatic logic [17:0] sum4(logic [63:0] v);
    return {2'b0, v[63:48]} + {2'b0, v[47:32]} + {2'b0, v[31:16]} + {2'b0, v[15:0]};
  endfunction

  function automatic kind_e to_kind(logic [2:0] opcode);
    kind_e k;
    case (opcode)
      KIND_TCP4, KIND_UDP4, KIND_ICMP4,
      KIND_TCP6, KIND_UDP6, KIND_ICMP6: k = kind_e'(opcode);
      default:                          k = KIND_IPV4_HDR;
    endcase
    return k;
  endfunction

  function automatic logic kind_is_v6(kind_e k);
    return (k == KIND_TCP6) || (k == KIND_UDP6) || (k == KIND_ICMP6);
  endfunction

  function automatic logic kind_is_v4_pseudo(kind_e k);
    return (k == KIND_TCP4) || (k == KIND_UDP4);
  endfunction

  function automatic logic [15:0] kind_proto(kind_e k);
    logic [15:0] p;
    case (k)
      KIND_TCP4, KIND_TCP6: p = PROTO_TCP;
      KIND_UDP4, KIND_UDP6: p = PROTO_UDP;
      KIND_ICMP6:           p = PROTO_ICMP6;
      default:              p = 16'd0;
    endcase
    return p;
  endfunction

  function automatic logic [17:0] kind_min_len(kind_e k);
    logic [17:0] m;
    case (k)
      KIND_UDP4, KIND_UDP6:   m = MIN_LEN_UDP;
      KIND_ICMP4, KIND_ICMP6: m = MIN_LEN_ICMP;
      default:                m = MIN_LEN_HDR;
    endcase
    return m;
  endfunction

endpackage

/* rtl/icv_front.sv */
// Front part: accepts words, classifies them and forms the pseudo-header seed.
module icv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          opcode_i,
  input  logic [63:0]         src_high_i,
  input  logic [63:0]         src_low_i,
  input  logic [63:0]         dst_high_i,
  input  logic [63:0]         dst_low_i,
  input  logic [15:0]         data_word_i,
  input  logic                both_bytes_i,
  input  logic                first_item_i,
  input  logic                last_item_i,
  output logic                push_o,
  output icv_pkg::icv_item_t  item_o,
  input  logic                queue_ready_i
);

  icv_pkg::kind_e kind;
  logic           v6;
  logic           v4p;
  logic [18:0]    g0_d, g1_d, g2_d, g3_d;

  logic           valid_q;
  icv_pkg::kind_e kind_q;
  logic           first_q, last_q, both_q;
  logic [15:0]    word_q;
  logic [18:0]    g0_q, g1_q, g2_q, g3_q;

  logic [20:0]    total;
  logic [16:0]    fold1;
  logic [15:0]    fold2;

  assign in_ready_o = !valid_q || queue_ready_i;

  // Partial sums of the pseudo-header address words, zero when not a seeding word.
  always_comb begin
    kind = icv_pkg::to_kind(opcode_i);
    v6   = first_item_i && icv_pkg::kind_is_v6(kind);
    v4p  = first_item_i && icv_pkg::kind_is_v4_pseudo(kind);
    g0_d = '0;
    g1_d = '0;
    g2_d = '0;
    g3_d = '0;
    if (v6) begin
      g0_d = {1'b0, icv_pkg::sum4(src_high_i)};
      g1_d = {1'b0, icv_pkg::sum4(src_low_i)};
      g2_d = {1'b0, icv_pkg::sum4(dst_high_i)};
      g3_d = {1'b0, icv_pkg::sum4(dst_low_i)} + {3'b0, icv_pkg::kind_proto(kind)};
    end else if (v4p) begin
      g1_d = {1'b0, icv_pkg::sum4({32'd0, src_low_i[31:0]})};
      g3_d = {1'b0, icv_pkg::sum4({32'd0, dst_low_i[31:0]})}
           + {3'b0, icv_pkg::kind_proto(kind)};
    end
  end

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      kind_q  <= kind;
      first_q <= first_item_i;
      last_q  <= last_item_i;
      both_q  <= both_bytes_i;
      word_q  <= both_bytes_i ? data_word_i : {data_word_i[15:8], 8'h00};
      g0_q    <= g0_d;
      g1_q    <= g1_d;
      g2_q    <= g2_d;
      g3_q    <= g3_d;
    end
  end

  // Combine the partial sums with the word and fold to 16 bits.
  always_comb begin
    total = {2'b0, g0_q} + {2'b0, g1_q} + {2'b0, g2_q} + {2'b0, g3_q} + {5'b0, word_q};
    fold1 = {1'b0, total[15:0]} + {12'd0, total[20:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
  end

  always_comb begin
    item_o.first   = first_q;
    item_o.last    = last_q;
    item_o.both    = both_q;
    item_o.kind    = kind_q;
    item_o.word    = word_q;
    item_o.contrib = fold2;
  end

  assign push_o = valid_q;

endmodule

/* rtl/icv_fifo.sv */
// Short queue of classified words between the front and back parts.
module icv_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  icv_pkg::icv_item_t  item_i,
  output logic                ready_o,
  output logic                valid_o,
  output icv_pkg::icv_item_t  item_o,
  input  logic                pop_i
);

  localparam int unsigned PtrW = $clog2(icv_pkg::QUEUE_DEPTH);

  icv_pkg::icv_item_t slots_q [icv_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push, do_pop;

  assign ready_o = (count_q != (PtrW+1)'(icv_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* rtl/icv_back.sv */
// Back part: keeps the running sum and byte count, and judges each finished segment.
module icv_back #(
  parameter int unsigned MaxSegmentBytes = 65535
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  icv_pkg::icv_item_t  item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                passed_o,
  output logic [1:0]          status_o,
  output logic [15:0]         folded_sum_o
);

  localparam logic [17:0] Limit   = 18'(MaxSegmentBytes + 1);
  localparam logic [17:0] MaxLen  = 18'(MaxSegmentBytes);

  // Segment state.
  logic [15:0]     sum_q;
  logic [16:0]     bytes_q;
  icv_pkg::kind_e  kind_q;
  logic [15:0]     udp_q;
  logic            in_seg_q;

  logic [15:0]     base_sum, sum_n;
  logic [16:0]     base_bytes, bytes_n;
  logic [17:0]     bytes_wide;
  logic [15:0]     base_udp, udp_n;
  icv_pkg::kind_e  kind_n;
  logic            active, makes_result;

  icv_pkg::icv_job_t job_q;
  logic              job_valid_q, job_move;

  logic [15:0]       fin_sum, fin_s1;
  icv_pkg::status_e  fin_status;
  logic [17:0]       fin_len;

  logic              out_valid_q;
  logic              passed_q;
  logic [1:0]        status_q;
  logic [15:0]       folded_q;

  // Next segment state from the word at the head of the queue.
  always_comb begin
    base_sum   = item_i.first ? 16'd0 : sum_q;
    base_bytes = item_i.first ? 17'd0 : bytes_q;
    base_udp   = item_i.first ? 16'd0 : udp_q;
    kind_n     = item_i.first ? item_i.kind : kind_q;
    active     = item_i.first || in_seg_q;
    udp_n      = (base_bytes == icv_pkg::UDP_FIELD_OFFSET) ? item_i.word : base_udp;
    sum_n      = icv_pkg::oc_add(base_sum, item_i.contrib);
    bytes_wide = {1'b0, base_bytes} + (item_i.both ? 18'd2 : 18'd1);
    bytes_n    = (bytes_wide > Limit) ? Limit[16:0] : bytes_wide[16:0];
    makes_result = active && item_i.last;
  end

  assign job_move = !out_valid_q || out_ready_i;
  assign pop_o    = valid_i && (!makes_result || !job_valid_q || job_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      bytes_q  <= '0;
      kind_q   <= icv_pkg::KIND_IPV4_HDR;
      udp_q    <= '0;
      in_seg_q <= 1'b0;
    end else if (pop_o && active) begin
      sum_q    <= sum_n;
      bytes_q  <= bytes_n;
      kind_q   <= kind_n;
      udp_q    <= udp_n;
      in_seg_q <= !item_i.last;
    end
  end

  // Finished segment waiting for its verdict.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else begin
      job_valid_q <= (job_valid_q && !job_move) || (pop_o && makes_result);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && makes_result) begin
      job_q.kind  <= kind_n;
      job_q.sum   <= sum_n;
      job_q.bytes <= bytes_n;
      job_q.udp   <= udp_n;
    end
  end

  // Add the counted length into any pseudo-header and judge the segment.
  always_comb begin
    fin_len = {1'b0, job_q.bytes};
    fin_s1  = icv_pkg::oc_add(job_q.sum, {15'd0, job_q.bytes[16]});
    if (icv_pkg::kind_is_v6(job_q.kind)) begin
      fin_sum = icv_pkg::oc_add(fin_s1, job_q.bytes[15:0]);
    end else if (icv_pkg::kind_is_v4_pseudo(job_q.kind)) begin
      fin_sum = icv_pkg::oc_add(job_q.sum, job_q.bytes[15:0]);
    end else begin
      fin_sum = job_q.sum;
    end
    if ((fin_len < icv_pkg::kind_min_len(job_q.kind)) || (fin_len > MaxLen)) begin
      fin_status = icv_pkg::STATUS_LENGTH;
    end else if ((job_q.kind == icv_pkg::KIND_UDP4) && (job_q.udp == 16'd0)) begin
      fin_status = icv_pkg::STATUS_UDP_ZERO;
    end else if (fin_sum == icv_pkg::SUM_ALL_ONES) begin
      fin_status = icv_pkg::STATUS_GOOD;
    end else begin
      fin_status = icv_pkg::STATUS_BAD;
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_move) begin
      out_valid_q <= job_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_move && job_valid_q) begin
      passed_q <= (fin_status == icv_pkg::STATUS_GOOD) ||
                  (fin_status == icv_pkg::STATUS_UDP_ZERO);
      status_q <= fin_status;
      folded_q <= fin_sum;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign passed_o     = passed_q;
  assign status_o     = status_q;
  assign folded_sum_o = folded_q;

endmodule

/* rtl/internet_checksum_verifier.sv */
// Top level of the internet checksum verifier.
//
//  Channel  Dir  Request carries
//  s_axis   in   one 16-bit segment word, with kind and addresses on the first word
//  m_axis   out  one verdict per segment: passed, status, folded sum
//
// One word is taken every cycle while the input is ready; the end-around-carry adder
// loops through the sum register alone. A verdict passes the input, queue, job and
// result registers. After reset the block is ready at once; no memory is cleared.
// A stalled output holds the result register and one finished segment behind it;
// words keep draining until the next last word reaches the head of the four-entry
// queue, and the input is held off only once that queue and the input register fill.
module internet_checksum_verifier #(
  parameter int unsigned MaxSegmentBytes = 65535
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // src_high[63:0] src_low[127:64] dst_high[191:128] dst_low[255:192] data_word[271:256]
  input  logic [271:0] s_axis_tdata,
  // opcode[2:0] both_bytes[3] first_item[4]
  input  logic [4:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // folded_sum[15:0]
  output logic [15:0]  m_axis_tdata,
  // passed[0] status[2:1]
  output logic [2:0]   m_axis_tuser
);

  icv_pkg::icv_item_t push_item, head_item;
  logic push, queue_ready, head_valid, pop;
  logic passed;
  logic [1:0] status;

  icv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .opcode_i      (s_axis_tuser[2:0]),
    .src_high_i    (s_axis_tdata[63:0]),
    .src_low_i     (s_axis_tdata[127:64]),
    .dst_high_i    (s_axis_tdata[191:128]),
    .dst_low_i     (s_axis_tdata[255:192]),
    .data_word_i   (s_axis_tdata[271:256]),
    .both_bytes_i  (s_axis_tuser[3]),
    .first_item_i  (s_axis_tuser[4]),
    .last_item_i   (s_axis_tlast),
    .push_o        (push),
    .item_o        (push_item),
    .queue_ready_i (queue_ready)
  );

  icv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (queue_ready),
    .valid_o (head_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  icv_back #(
    .MaxSegmentBytes (MaxSegmentBytes)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (head_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .passed_o     (passed),
    .status_o     (status),
    .folded_sum_o (m_axis_tdata)
  );

  assign m_axis_tuser = {status, passed};

endmodule

/* rtl/icv_checker.sv */
// Port-level checks for the checksum verifier, bound to the top level.
module icv_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [15:0]  m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  logic [15:0] pending_q;
  logic        in_last, out_take;

  assign in_last  = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_take = m_axis_tvalid && m_axis_tready;

  // Count last words taken that have not yet given a verdict.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      case ({in_last, out_take})
        2'b10:   pending_q <= pending_q + 1'b1;
        2'b01:   pending_q <= pending_q - 1'b1;
        default: pending_q <= pending_q;
      endcase
    end
  end

  a_no_result_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result shown during reset");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take |-> (pending_q != 16'd0))
    else $error("result without a last word taken before it");

  a_passed_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] ==
      ((m_axis_tuser[2:1] == icv_pkg::STATUS_GOOD) ||
       (m_axis_tuser[2:1] == icv_pkg::STATUS_UDP_ZERO))))
    else $error("passed flag disagrees with status");

  a_good_means_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[2:1] == icv_pkg::STATUS_GOOD)) |->
      (m_axis_tdata == icv_pkg::SUM_ALL_ONES))
    else $error("good status with a folded sum other than all ones");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind internet_checksum_verifier icv_checker u_icv_checker (.*);
